[hdl/lookahead_peak_limiter_assert.svh]
// Assertion macros for the lookahead peak limiter.
// Used by hdl/lookahead_peak_limiter.sv; no other dependencies.
`ifndef LOOKAHEAD_PEAK_LIMITER_ASSERT_SVH
`define LOOKAHEAD_PEAK_LIMITER_ASSERT_SVH
`define LPL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hdl/lpl_pkg.sv]
// Package for the lookahead peak limiter: widths, constants, sequencer states.
// No dependencies.
package lpl_pkg;
    localparam int SAMPLE_W = 24;
    localparam int DRIVE_W  = 28;
    localparam int GAIN_W   = 17;
    localparam int DELAY_DEPTH = 512;
    localparam logic [16:0] UNITY = 17'd65536;
    localparam logic [23:0] ONE_Q23 = 24'd8388608;

    localparam logic [2:0] REG_PRE_GAIN  = 3'd0;
    localparam logic [2:0] REG_OUT_GAIN  = 3'd1;
    localparam logic [2:0] REG_ATTACK    = 3'd2;
    localparam logic [2:0] REG_RELEASE   = 3'd3;
    localparam logic [2:0] REG_LOOKAHEAD = 3'd4;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_DRIVE = 11'b00000000010,
        ST_DIV1  = 11'b00000000100,
        ST_FOLL  = 11'b00000001000,
        ST_READ  = 11'b00000010000,
        ST_LIM   = 11'b00000100000,
        ST_DIV2  = 11'b00001000000,
        ST_SAFE  = 11'b00010000000,
        ST_TRIM  = 11'b00100000000,
        ST_DONE  = 11'b01000000000,
        ST_FOLL2 = 11'b10000000000
    } state_t;
endpackage

[hdl/lookahead_peak_limiter.sv]
// Stereo lookahead peak limiter top level: sequencer, shared multiplier, divider.
// Depends on lpl_pkg and lookahead_peak_limiter_assert.svh.
//
// Usage:
//   Input words (in_left/in_right) are taken when in_valid is high and in_stall
//   is low. in_stall stays high while a word is in work.
//   Result words (out_left, out_right, current_gain, in_peak, out_peak) are held
//   in an output register under out_valid until the receiver lowers out_stall.
//   Each reciprocal gain needs a 40 step radix-2 divide, done only when its peak
//   exceeds unity (detect peak, then post-gain peak).
//   One shared 28x20 multiplier serves all products, one per cycle.
//   The block takes no new word until the last one is finished; a finished
//   word waits in the last state while the previous result is stalled.
//   Delay line: a DELAY_DEPTH-deep memory of driven pairs. After reset a
//   clearing pass zeroes it; no input word is taken then.
//   Configuration registers are written through the APB port; pready is high.
//   Reset clears the sequencer and write pointer, presets the gain and registers.
//   Write configuration only while the block is idle.
module lookahead_peak_limiter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [23:0] in_left,
    input  logic signed [23:0] in_right,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [23:0] out_left,
    output logic signed [23:0] out_right,
    output logic [16:0] current_gain,
    output logic [23:0] in_peak,
    output logic [23:0] out_peak,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lpl_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);

    logic [19:0] pre_gain_reg;
    logic [16:0] out_gain_reg;
    logic [15:0] attack_reg, release_reg;
    logic [8:0]  lookahead_reg;

    assign pready = 1'b1;
    logic [2:0] reg_idx;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_gain_reg  <= 20'd73533;
            out_gain_reg  <= 17'd65536;
            attack_reg    <= 16'd64065;
            release_reg   <= 16'd65528;
            lookahead_reg <= 9'd221;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_PRE_GAIN:  pre_gain_reg  <= pwdata[19:0];
                REG_OUT_GAIN:  out_gain_reg  <= pwdata[16:0];
                REG_ATTACK:    attack_reg    <= pwdata[15:0];
                REG_RELEASE:   release_reg   <= pwdata[15:0];
                REG_LOOKAHEAD: lookahead_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PRE_GAIN:  prdata = {12'd0, pre_gain_reg};
            REG_OUT_GAIN:  prdata = {15'd0, out_gain_reg};
            REG_ATTACK:    prdata = {16'd0, attack_reg};
            REG_RELEASE:   prdata = {16'd0, release_reg};
            REG_LOOKAHEAD: prdata = {23'd0, lookahead_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // delay memory
    logic [55:0]   mem [DELAY_DEPTH];
    logic [55:0]   rd_data_reg;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [55:0]   wdata;
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    state_t state_reg, state_next;
    logic          clr_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] wp_reg;
    logic [16:0]   gain_reg;
    logic          ch_reg;       // channel / step within a state
    logic [5:0]    cnt_reg;      // divider step count

    logic signed [23:0] sl_reg, sr_reg;
    logic signed [27:0] dl_reg, dr_reg;   // driven, then limited values
    logic [27:0]   pk_reg;                // detect / post peak
    logic [16:0]   recip_reg;
    logic [39:0]   rem_reg;
    logic [39:0]   quo_reg;
    logic [33:0]   acc_reg;               // follower sum
    logic [16:0]   target_reg;
    logic [15:0]   coef_reg;
    logic signed [23:0] ol_reg, or_reg;
    logic [23:0]   ipk_reg, opk_reg;
    logic          ovalid_reg;
    logic signed [23:0] res_left_reg, res_right_reg;
    logic [16:0]   res_gain_reg;
    logic [23:0]   res_ipk_reg, res_opk_reg;

    // shared multiplier: magnitude x gain, rounded
    logic [27:0] m_a;
    logic [19:0] m_b;
    logic [47:0] m_p;
    logic [31:0] m_r;
    assign m_p = 48'(m_a) * 48'(m_b);
    assign m_r = m_p[47:16] + 32'(m_p[15]);

    function automatic logic [27:0] mag28(input logic signed [27:0] v);
        return v[27] ? 28'(-v) : 28'(v);
    endfunction

    logic signed [27:0] op_v;
    logic               op_neg;
    logic signed [31:0] op_s;
    always_comb
    begin
        op_v = '0;
        m_b  = '0;
        unique case (state_reg)
            ST_DRIVE: begin op_v = ch_reg ? 28'(sr_reg) : 28'(sl_reg); m_b = pre_gain_reg; end
            ST_LIM:   begin op_v = ch_reg ? dr_reg : dl_reg; m_b = 20'(gain_reg); end
            ST_SAFE:  begin op_v = ch_reg ? dr_reg : dl_reg; m_b = 20'(recip_reg); end
            ST_TRIM:  begin op_v = ch_reg ? dr_reg : dl_reg; m_b = 20'(out_gain_reg); end
            ST_FOLL:  begin op_v = 28'(target_reg); m_b = 20'(17'(UNITY - 17'(coef_reg))); end
            ST_FOLL2: begin op_v = 28'(gain_reg); m_b = 20'(coef_reg); end
            default: ;
        endcase
    end
    assign m_a    = mag28(op_v);
    assign op_neg = op_v[27];
    assign op_s   = op_neg ? -$signed(m_r) : $signed(m_r);

    logic signed [31:0] sat28;
    assign sat28 = (op_s > 32'sd134217727) ? 32'sd134217727 :
                   (op_s < -32'sd134217728) ? -32'sd134217728 : op_s;
    logic signed [31:0] sat24;
    assign sat24 = (op_s > 32'sd8388607) ? 32'sd8388607 :
                   (op_s < -32'sd8388608) ? -32'sd8388608 : op_s;
    logic [27:0] sat28_mag;
    assign sat28_mag = mag28(28'(sat28));
    logic [27:0] lim_mag;
    assign lim_mag = mag28(28'(op_s));
    logic [23:0] s24_mag;
    assign s24_mag = sat24[31] ? 24'(-sat24) : 24'(sat24);

    // divider step: 2^39 / pk
    logic [40:0] rem_sh;
    logic        dq;
    assign rem_sh = {rem_reg, quo_reg[39]};
    assign dq     = rem_sh >= 41'(pk_reg);

    logic [AW-1:0] sh;
    assign sh = AW'(lookahead_reg % DELAY_DEPTH);

    logic [33:0] fsum;
    assign fsum = acc_reg + 34'(m_p[33:0]);

    logic in_acc, out_acc;
    assign in_stall  = (state_reg != ST_IDLE) || clr_reg;
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = ovalid_reg && !out_stall;

    always_comb
    begin
        we    = 1'b0;
        waddr = wp_reg;
        wdata = {dl_reg, dr_reg};
        raddr = wp_reg - sh;
        if (clr_reg)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end
        else if (state_reg == ST_DIV1 && cnt_reg == 6'd0)
            we = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_DRIVE;
            ST_DRIVE: if (ch_reg) state_next = ST_DIV1;
            ST_DIV1:  if (cnt_reg == 6'd40 || pk_reg <= 28'(ONE_Q23)) state_next = ST_FOLL;
            ST_FOLL:  state_next = ST_FOLL2;
            ST_FOLL2: state_next = ST_READ;
            ST_READ:  state_next = ST_LIM;
            ST_LIM:   if (ch_reg) state_next = ST_DIV2;
            ST_DIV2:  if (cnt_reg == 6'd40 || pk_reg <= 28'(ONE_Q23)) state_next = ST_SAFE;
            ST_SAFE:  if (ch_reg) state_next = ST_TRIM;
            ST_TRIM:  if (ch_reg) state_next = ST_DONE;
            ST_DONE:  if (!ovalid_reg || out_acc) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            wp_reg      <= '0;
            gain_reg    <= UNITY;
            ch_reg      <= 1'b0;
            cnt_reg     <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DELAY_DEPTH - 1))
                    clr_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && state_next == ST_IDLE)
                ovalid_reg <= 1'b1;
            else if (out_acc)
                ovalid_reg <= 1'b0;
            unique case (state_reg) inside
                ST_DRIVE, ST_LIM, ST_SAFE, ST_TRIM: ch_reg <= !ch_reg;
                ST_DIV1, ST_DIV2:
                    cnt_reg <= (state_next != state_reg) ? 6'd0 : cnt_reg + 1'b1;
                ST_FOLL2: gain_reg <= (target_reg > gain_reg) ?
                    17'((fsum + 34'd65535) >> 16) : 17'(fsum >> 16);
                ST_DONE:
                    if (state_next == ST_IDLE)
                        wp_reg <= (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg) inside
            ST_IDLE:
                if (in_acc)
                begin
                    sl_reg  <= in_left;
                    sr_reg  <= in_right;
                    pk_reg  <= '0;
                    ipk_reg <= (mag28(28'(in_left)) > mag28(28'(in_right))) ?
                               24'(mag28(28'(in_left))) : 24'(mag28(28'(in_right)));
                end
            ST_DRIVE:
            begin
                if (ch_reg) dr_reg <= 28'(sat28); else dl_reg <= 28'(sat28);
                if (sat28_mag > pk_reg) pk_reg <= sat28_mag;
                rem_reg <= '0;
                quo_reg <= 40'h80_0000_0000;
            end
            ST_DIV1, ST_DIV2:
            begin
                if (cnt_reg != 6'd40)
                begin
                    rem_reg <= dq ? 40'(rem_sh - 41'(pk_reg)) : rem_sh[39:0];
                    quo_reg <= {quo_reg[38:0], dq};
                end
                if (state_next != state_reg)
                begin
                    if (state_reg == ST_DIV1)
                    begin
                        target_reg <= (pk_reg <= 28'(ONE_Q23)) ? UNITY : quo_reg[16:0];
                        coef_reg   <= (((pk_reg <= 28'(ONE_Q23)) ? UNITY : quo_reg[16:0])
                                      < gain_reg) ? attack_reg : release_reg;
                    end
                    else
                        recip_reg <= (pk_reg <= 28'(ONE_Q23)) ? UNITY : quo_reg[16:0];
                end
            end
            ST_FOLL: acc_reg <= m_p[33:0];
            ST_READ: pk_reg  <= '0;
            ST_LIM:
            begin
                if (!ch_reg)
                begin
                    dl_reg <= 28'(op_s);
                    dr_reg <= rd_data_reg[27:0];
                    // left operand taken from memory in the cycle before
                end
                else
                    dr_reg <= 28'(op_s);
                if (lim_mag > pk_reg) pk_reg <= lim_mag;
                rem_reg <= '0;
                quo_reg <= 40'h80_0000_0000;
                opk_reg <= '0;
            end
            ST_SAFE: if (ch_reg) dr_reg <= 28'(op_s); else dl_reg <= 28'(op_s);
            ST_TRIM:
            begin
                if (ch_reg) or_reg <= 24'(sat24); else ol_reg <= 24'(sat24);
                if (s24_mag > opk_reg) opk_reg <= s24_mag;
            end
            ST_DONE:
                if (state_next == ST_IDLE)
                begin
                    res_left_reg  <= ol_reg;
                    res_right_reg <= or_reg;
                    res_gain_reg  <= gain_reg;
                    res_ipk_reg   <= ipk_reg;
                    res_opk_reg   <= opk_reg;
                end
            default: ;
        endcase
        if (state_reg == ST_READ)
        begin
            dl_reg <= rd_data_reg[55:28];
            dr_reg <= rd_data_reg[27:0];
        end
    end

    assign out_valid    = ovalid_reg;
    assign out_left     = res_left_reg;
    assign out_right    = res_right_reg;
    assign current_gain = res_gain_reg;
    assign in_peak      = res_ipk_reg;
    assign out_peak     = res_opk_reg;

    `include "lookahead_peak_limiter_assert.svh"
    `LPL_ASSERT_IMPL(a_no_accept_in_clear, clr_reg, !in_acc, "input taken during clear")
    `LPL_ASSERT_IMPL(a_gain_range, 1'b1, gain_reg <= UNITY, "gain above unity")
    `LPL_ASSERT_NEXT(a_done_valid, state_reg == ST_DONE, ovalid_reg, "result not posted")
    `LPL_ASSERT_IMPL(a_busy_stall, state_reg != ST_IDLE, in_stall, "ready while busy")
endmodule

[tb/lookahead_peak_limiter_checker.sv]
// Checker for the lookahead peak limiter: follows APB writes and both word channels,
// predicts each result word and compares it field by field. Depends on lpl_pkg.
module lookahead_peak_limiter_checker #(
    parameter int DEPTH = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [23:0] in_left,
    input  logic signed [23:0] in_right,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [23:0] out_left,
    input  logic signed [23:0] out_right,
    input  logic [16:0]        current_gain,
    input  logic [23:0]        in_peak,
    input  logic [23:0]        out_peak,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending
);
    import lpl_pkg::*;

    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic [16:0]        gain;
        logic [23:0]        ipk;
        logic [23:0]        opk;
    } limit_word_t;

    limit_word_t expected_words[$];

    longint line_mem[DEPTH][2];
    int     wr_ptr;
    longint gain_q16;
    logic [19:0] drive_gain;
    logic [16:0] trim_gain;
    logic [15:0] atk_c;
    logic [15:0] rel_c;
    logic [8:0]  look_frames;

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint scale_rnd(longint v, longint g);
        longint m;
        m = (absl(v) * g + 32768) >>> 16;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint recip_q16(longint pk);
        if (pk > 8388608)
            return (64'sd1 <<< 39) / pk;
        return 65536;
    endfunction

    task automatic limit_frame(input logic signed [23:0] l, input logic signed [23:0] r);
        longint s[2];
        longint d;
        longint ipk, dpk, ppk, opk, tgt, c, num, v, sg;
        longint lim[2];
        longint res[2];
        int rp;
        limit_word_t w;
        s[0] = l;
        s[1] = r;
        ipk = 0; dpk = 0; ppk = 0; opk = 0;
        for (int ch = 0; ch < 2; ch++)
        begin
            d = scale_rnd(s[ch], drive_gain);
            if (absl(s[ch]) > ipk) ipk = absl(s[ch]);
            if (d > 134217727) d = 134217727;
            if (d < -134217728) d = -134217728;
            line_mem[wr_ptr][ch] = d;
            if (absl(d) > dpk) dpk = absl(d);
        end
        tgt = recip_q16(dpk);
        c = (tgt < gain_q16) ? atk_c : rel_c;
        num = tgt * (65536 - c) + gain_q16 * c;
        if (tgt > gain_q16)
            gain_q16 = (num + 65535) >>> 16;
        else
            gain_q16 = num >>> 16;
        rp = (wr_ptr + DEPTH - (look_frames % DEPTH)) % DEPTH;
        for (int ch = 0; ch < 2; ch++)
        begin
            lim[ch] = scale_rnd(line_mem[rp][ch], gain_q16);
            if (absl(lim[ch]) > ppk) ppk = absl(lim[ch]);
        end
        sg = recip_q16(ppk);
        for (int ch = 0; ch < 2; ch++)
        begin
            v = scale_rnd(scale_rnd(lim[ch], sg), trim_gain);
            if (v > 8388607) v = 8388607;
            if (v < -8388608) v = -8388608;
            if (absl(v) > opk) opk = absl(v);
            res[ch] = v;
        end
        w.left  = res[0][23:0];
        w.right = res[1][23:0];
        w.gain  = gain_q16[16:0];
        w.ipk   = ipk[23:0];
        w.opk   = opk[23:0];
        expected_words.push_back(w);
        wr_ptr = (wr_ptr + 1) % DEPTH;
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    assign pending = expected_words.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_mem[i][0] = 0;
                line_mem[i][1] = 0;
            end
            wr_ptr      = 0;
            gain_q16    = 65536;
            drive_gain  = 20'd73533;
            trim_gain   = 17'd65536;
            atk_c       = 16'd64065;
            rel_c       = 16'd65528;
            look_frames = 9'd221;
            expected_words.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_PRE_GAIN:  drive_gain  = pwdata[19:0];
                    REG_OUT_GAIN:  trim_gain   = pwdata[16:0];
                    REG_ATTACK:    atk_c       = pwdata[15:0];
                    REG_RELEASE:   rel_c       = pwdata[15:0];
                    REG_LOOKAHEAD: look_frames = pwdata[8:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result word, actual left %0d right %0d",
                             $time, out_left, out_right);
                    fail_count++;
                end
                else
                begin
                    limit_word_t e;
                    e = expected_words.pop_front();
                    check_field("out_left", e.left, out_left);
                    check_field("out_right", e.right, out_right);
                    check_field("current_gain", e.gain, current_gain);
                    check_field("in_peak", e.ipk, in_peak);
                    check_field("out_peak", e.opk, out_peak);
                end
            end
            if (in_valid && !in_stall)
                limit_frame(in_left, in_right);
        end
    end

endmodule

[tb/lookahead_peak_limiter_tb.sv]
// Top of the lookahead peak limiter testbench: clock, reset, APB setup, word stimulus,
// receiver stalls and verdict. Depends on lpl_pkg, lookahead_peak_limiter_checker and the RTL.
module lookahead_peak_limiter_tb;
    import lpl_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [23:0] in_left = '0;
    logic signed [23:0] in_right = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [23:0] out_left;
    logic signed [23:0] out_right;
    logic [16:0]        current_gain;
    logic [23:0]        in_peak;
    logic [23:0]        out_peak;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 cycles = 0;

    always #2 clk = ~clk;

    lookahead_peak_limiter DUT (.*);

    lookahead_peak_limiter_checker chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == 1000000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limiter(input logic [19:0] pg, input logic [16:0] og,
                               input logic [15:0] atk, input logic [15:0] rel,
                               input logic [8:0] la);
        apb_write(REG_PRE_GAIN, 32'(pg));
        apb_write(REG_OUT_GAIN, 32'(og));
        apb_write(REG_ATTACK, 32'(atk));
        apb_write(REG_RELEASE, 32'(rel));
        apb_write(REG_LOOKAHEAD, 32'(la));
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send_word(input logic signed [23:0] l, input logic signed [23:0] r);
        in_valid <= 1'b1;
        in_left  <= l;
        in_right <= r;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 4))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 131071) - 65536);
            2: return $urandom_range(0, 1) ? 24'(24'h7fffff - $urandom_range(0, 4095))
                                           : 24'(24'h800000 + $urandom_range(0, 4095));
            3: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            default: return 24'($urandom_range(0, 2097151) - 1048576);
        endcase
    endfunction

    task automatic random_words(input int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < n; i++)
            begin
                send_word(rand_sample(), rand_sample());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 40));
        end
        idle_cycles(1);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_limiter(20'd1038579, 17'd65536, 16'd0, 16'd65535, 9'd0);
        send_word(24'sd0, 24'sd0);
        send_word(24'sh7fffff, 24'sh7fffff);
        send_word(-24'sd8388608, -24'sd8388608);
        send_word(24'sh7fffff, -24'sd8388608);
        send_word(24'sd1, -24'sd1);
        send_word(24'sd529, 24'sd0);
        send_word(24'sd0, -24'sd529);
        send_word(24'sh555555, 24'shaaaaaa);
        idle_cycles(3);
        send_word(24'shaaaaaa, 24'sh555555);
        send_word(24'sd0, 24'sd0);
        idle_cycles(1);
        drain();

        set_limiter(20'd65536, 17'd131071, 16'd65535, 16'd0, 9'd1);
        send_word(24'sh7fffff, -24'sd8388608);
        send_word(24'sh400000, 24'sh3fffff);
        send_word(24'sd0, 24'sd0);
        send_word(-24'sd8388608, 24'sd12345);
        send_word(24'sd4096, -24'sd4096);
        send_word(24'sh7fffff, 24'sh7fffff);
        idle_cycles(1);
        drain();

        set_limiter(20'd73533, 17'd4135, 16'd64065, 16'd65528, 9'd221);
        random_words(190);
        drain();
        set_limiter(20'd1038579, 17'd65536, 16'd0, 16'd0, 9'd511);
        random_words(190);
        drain();
        set_limiter(20'd65536, 17'd98304, 16'd65535, 16'd65535, 9'd3);
        random_words(180);
        drain();
        set_limiter(20'd524288, 17'd40000, 16'd32768, 16'd1000, 9'd0);
        random_words(180);
        drain();
        set_limiter(20'd200000, 17'd65535, 16'd50000, 16'd60000, 9'd17);
        random_words(180);
        drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int rounds;
        int hold;
        rounds = 0;
        @(posedge rst_n);
        forever
        begin
            rounds++;
            if (rounds == 15)
            begin
                out_stall <= 1'b1;
                hold = 0;
                while (hold < 800)
                begin
                    @(posedge clk);
                    hold++;
                end
            end
            case ($urandom_range(0, 2))
                0:
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(20, 300)) @(posedge clk);
                end
                1:
                begin
                    repeat ($urandom_range(20, 200))
                    begin
                        out_stall <= ($urandom_range(0, 2) == 0);
                        @(posedge clk);
                    end
                end
                default:
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 60)) @(posedge clk);
                end
            endcase
        end
    end

endmodule
